// File: rtl/auto_ranging_capture_control_core_assert.svh
// Assertion helpers, sampled on clk and disabled while rst_n is low
`ifndef AUTO_RANGING_CAPTURE_CONTROL_CORE_ASSERT_SVH
`define AUTO_RANGING_CAPTURE_CONTROL_CORE_ASSERT_SVH

// Check that cond implies prop in the same cycle
`define ARCC_ASSERT_IMP(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check that cond implies prop in the next cycle
`define ARCC_ASSERT_NXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: rtl/arcc_pkg.sv
`timescale 1ns / 1ps

package arcc_pkg;

    localparam int PROBE_LEN    = 256;
    localparam int NUM_CHANNELS = 6;

    localparam logic [15:0] PROBE_LEN_W    = 16'(PROBE_LEN);
    localparam logic [3:0]  NUM_CHANNELS_W = 4'(NUM_CHANNELS);

    localparam logic [11:0] MID_RAIL = 12'd2048;

    localparam logic [11:0] HIGH_THRESHOLD_RST = 12'd1800;
    localparam logic [11:0] LOW_THRESHOLD_RST  = 12'd120;
    localparam logic [15:0] CAPTURE_LEN_RST    = 16'd8192;

    localparam logic [1:0] CFG_HIGH_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_LOW_THRESHOLD  = 2'd1;
    localparam logic [1:0] CFG_CAPTURE_LEN    = 2'd2;

    localparam logic [1:0] FUNC_START   = 2'd0;
    localparam logic [1:0] FUNC_SAMPLE  = 2'd1;
    localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

    localparam logic [1:0] KIND_SETUP  = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_TIMEOUT = 2'd1;
    localparam logic [1:0] STAT_RANGE   = 2'd2;

    localparam logic [2:0] GAIN_LOW   = 3'd0;
    localparam logic [2:0] GAIN_PROBE = 3'd3;
    localparam logic [2:0] GAIN_HIGH  = 3'd5;

    typedef struct packed {
        logic [11:0] high_threshold;
        logic [11:0] low_threshold;
        logic [15:0] capture_len;
    } arcc_cfg_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  channel;
        logic [11:0] adc_sample;
    } arcc_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         mux_select;
        logic [2:0]         gain_index;
        logic signed [11:0] sample_value;
        logic [1:0]         status;
        logic               last;
    } arcc_result_t;

    function automatic logic [2:0] mux_code(input logic [2:0] chan);
        return {chan[0], chan[1], chan[2]};
    endfunction

    function automatic logic [11:0] magnitude(input logic [11:0] raw);
        return (raw >= MID_RAIL) ? (raw - MID_RAIL) : (MID_RAIL - raw);
    endfunction

endpackage

// File: rtl/arcc_if.sv
`timescale 1ns / 1ps

interface arcc_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [2:0]  channel;
    logic [11:0] adc_sample;

    modport source (output valid, func, channel, adc_sample, input ready);
    modport sink (input valid, func, channel, adc_sample, output ready);
endinterface

interface arcc_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [2:0]         mux_select;
    logic [2:0]         gain_index;
    logic signed [11:0] sample_value;
    logic [1:0]         status;
    logic               last;

    modport source (output valid, kind, mux_select, gain_index, sample_value, status, last,
                    input ready);
    modport sink (input valid, kind, mux_select, gain_index, sample_value, status, last,
                  output ready);
endinterface

interface arcc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/arcc_cfg_regs.sv
`timescale 1ns / 1ps

module arcc_cfg_regs
(
    input  logic               clk,
    input  logic               rst_n,
    arcc_cfg_if.sink           cfg,
    output arcc_pkg::arcc_cfg_t regs
);

    arcc_pkg::arcc_cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.high_threshold <= arcc_pkg::HIGH_THRESHOLD_RST;
            regs_reg.low_threshold  <= arcc_pkg::LOW_THRESHOLD_RST;
            regs_reg.capture_len    <= arcc_pkg::CAPTURE_LEN_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                arcc_pkg::CFG_HIGH_THRESHOLD: regs_reg.high_threshold <= cfg.data[11:0];
                arcc_pkg::CFG_LOW_THRESHOLD:  regs_reg.low_threshold  <= cfg.data[11:0];
                arcc_pkg::CFG_CAPTURE_LEN:    regs_reg.capture_len    <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

// File: rtl/arcc_in_stage.sv
`timescale 1ns / 1ps

module arcc_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    arcc_item_if.sink           item,
    input  logic                take,
    output logic                held_valid,
    output arcc_pkg::arcc_item_t held
);

    logic                 valid_reg;
    arcc_pkg::arcc_item_t item_reg;

    assign item.ready = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            item_reg  <= '0;
        end
        else if (item.ready)
        begin
            valid_reg           <= item.valid;
            item_reg.func       <= item.func;
            item_reg.channel    <= item.channel;
            item_reg.adc_sample <= item.adc_sample;
        end
    end

endmodule

// File: rtl/arcc_seq.sv
`timescale 1ns / 1ps
`include "auto_ranging_capture_control_core_assert.svh"

module arcc_seq
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  arcc_pkg::arcc_cfg_t  regs,
    input  logic                 held_valid,
    input  arcc_pkg::arcc_item_t held,
    output logic                 take,
    arcc_result_if.source        result
);

    typedef enum logic [1:0] {PH_IDLE, PH_PROBE, PH_CAPTURE} phase_t;

    phase_t                 phase_reg, phase_next;
    logic [15:0]            count_reg, count_next;
    logic [11:0]            peak_reg, peak_next;
    logic                   out_valid_reg, out_valid_next;
    arcc_pkg::arcc_result_t res_reg, res_next;

    logic                   emit;
    logic [15:0]            count_inc;
    logic [11:0]            mag;
    logic [11:0]            peak_upd;
    logic [11:0]            peak_pick;
    logic [2:0]             gain_pick;
    logic                   bad_chan;
    logic                   cap_last;

    assign take      = held_valid && (!out_valid_reg || result.ready);
    assign count_inc = count_reg + 16'd1;
    assign mag       = arcc_pkg::magnitude(held.adc_sample);
    assign peak_upd  = (mag > peak_reg) ? mag : peak_reg;
    assign bad_chan  = {1'b0, held.channel} >= arcc_pkg::NUM_CHANNELS_W;
    assign cap_last  = (count_inc >= regs.capture_len) || (count_inc == 16'd0);
    assign peak_pick = (held.func == arcc_pkg::FUNC_SAMPLE) ? peak_upd : peak_reg;

    always_comb
    begin
        priority if (peak_pick > regs.high_threshold)
            gain_pick = arcc_pkg::GAIN_LOW;
        else if (peak_pick < regs.low_threshold)
            gain_pick = arcc_pkg::GAIN_HIGH;
        else
            gain_pick = arcc_pkg::GAIN_PROBE;
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        peak_next  = peak_reg;
        emit       = 1'b0;
        res_next   = '0;
        if (take)
        begin
            unique case (held.func)
                arcc_pkg::FUNC_START:
                begin
                    count_next = '0;
                    emit       = 1'b1;
                    if (bad_chan)
                    begin
                        phase_next      = PH_IDLE;
                        res_next.kind   = arcc_pkg::KIND_END;
                        res_next.status = arcc_pkg::STAT_RANGE;
                        res_next.last   = 1'b1;
                    end
                    else
                    begin
                        phase_next          = PH_PROBE;
                        peak_next           = '0;
                        res_next.kind       = arcc_pkg::KIND_SETUP;
                        res_next.mux_select = arcc_pkg::mux_code(held.channel);
                        res_next.gain_index = arcc_pkg::GAIN_PROBE;
                    end
                end
                arcc_pkg::FUNC_SAMPLE:
                begin
                    unique case (phase_reg)
                        PH_PROBE:
                        begin
                            peak_next  = peak_upd;
                            count_next = count_inc;
                            if (count_inc >= arcc_pkg::PROBE_LEN_W)
                            begin
                                phase_next          = PH_CAPTURE;
                                count_next          = '0;
                                emit                = 1'b1;
                                res_next.kind       = arcc_pkg::KIND_SETUP;
                                res_next.gain_index = gain_pick;
                            end
                        end
                        PH_CAPTURE:
                        begin
                            count_next            = cap_last ? 16'd0 : count_inc;
                            phase_next            = cap_last ? PH_IDLE : PH_CAPTURE;
                            emit                  = 1'b1;
                            res_next.kind         = arcc_pkg::KIND_SAMPLE;
                            res_next.sample_value = signed'(held.adc_sample - arcc_pkg::MID_RAIL);
                            res_next.last         = cap_last;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                arcc_pkg::FUNC_TIMEOUT:
                begin
                    unique case (phase_reg)
                        PH_PROBE:
                        begin
                            phase_next          = PH_CAPTURE;
                            count_next          = '0;
                            emit                = 1'b1;
                            res_next.kind       = arcc_pkg::KIND_SETUP;
                            res_next.gain_index = gain_pick;
                        end
                        PH_CAPTURE:
                        begin
                            phase_next      = PH_IDLE;
                            count_next      = '0;
                            emit            = 1'b1;
                            res_next.kind   = arcc_pkg::KIND_END;
                            res_next.status = arcc_pkg::STAT_TIMEOUT;
                            res_next.last   = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (take)
            out_valid_next = emit;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
            if (take && emit)
                res_reg <= res_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.kind         = res_reg.kind;
    assign result.mux_select   = res_reg.mux_select;
    assign result.gain_index   = res_reg.gain_index;
    assign result.sample_value = res_reg.sample_value;
    assign result.status       = res_reg.status;
    assign result.last         = res_reg.last;

    `ARCC_ASSERT_NXT(a_last_goes_idle, take && emit && res_next.last, phase_reg == PH_IDLE, "last beat left sequencer busy")
    `ARCC_ASSERT_IMP(a_idle_count_clear, phase_reg == PH_IDLE, count_reg == 16'd0, "idle with nonzero sample count")
    `ARCC_ASSERT_IMP(a_setup_busy, out_valid_reg && res_reg.kind == arcc_pkg::KIND_SETUP, phase_reg == PH_PROBE || phase_reg == PH_CAPTURE, "setup beat pending while idle")
    `ARCC_ASSERT_IMP(a_peak_bound, 1'b1, peak_reg <= arcc_pkg::MID_RAIL, "peak magnitude beyond mid rail")

endmodule

// File: rtl/auto_ranging_capture_control_core.sv
`timescale 1ns / 1ps
// Throughput: one item per clock, sustained, with the result port ready.
// An accepted item is held in the input register, and its result beat is then
// registered in the result register before it becomes valid.
// Items that produce no result still pass through the input register.
// Reset: phase idle, sample count and peak zero, thresholds 1800/120, capture length 8192.

module auto_ranging_capture_control_core
(
    input  logic          clk,
    input  logic          rst_n,
    arcc_item_if.sink     item,
    arcc_result_if.source result,
    arcc_cfg_if.sink      cfg
);

    arcc_pkg::arcc_cfg_t  regs;
    arcc_pkg::arcc_item_t held;
    logic                 held_valid;
    logic                 take;

    arcc_cfg_regs u_cfg_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    arcc_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .take       (take),
        .held_valid (held_valid),
        .held       (held)
    );

    arcc_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .regs       (regs),
        .held_valid (held_valid),
        .held       (held),
        .take       (take),
        .result     (result)
    );

endmodule
